// ===== sv/kr_pkg.sv =====
// Shared types and constants for the keyed record table.
// Record layout, action and status codes, cell control word.
// No dependencies.
package kr_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam int ACT_W   = 2;
  localparam int STAT_W  = 2;
  localparam int KEY_W   = 32;
  localparam int TEXT_W  = 64;
  localparam int VALUE_W = 31;
  localparam int POS_W   = 4;

  localparam int REC_W   = KEY_W + 2 * TEXT_W + VALUE_W;

  // bit offsets inside tdata, first field lowest
  localparam int NAME_LO  = KEY_W;
  localparam int TITLE_LO = NAME_LO + TEXT_W;
  localparam int VALUE_LO = TITLE_LO + TEXT_W;
  localparam int POS_LO   = VALUE_LO + VALUE_W;

  localparam int IN_DATA_W  = ((REC_W + POS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((REC_W + CNT_W + 7) / 8) * 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [TEXT_W-1:0]  title;
    logic [TEXT_W-1:0]  name;
    logic [KEY_W-1:0]   key;
  } rec_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_LOAD,
    CELL_CLOSE
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t       mode;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] mark;
  } cell_ctrl_t;

endpackage

// ===== sv/keyed_record_table_core.sv =====
// Keyed record table: up to ENTRIES records held in a chain of cells. Insert
// goes from accept straight to the finish state; search, read-at and delete
// first scan the chain, which rotates one record past the head cell per cycle
// until a full rotation restores the order, and a delete that removes a record
// then closes the gap; an empty table skips the scan. One word is in work at a
// time; a new word is taken while the previous result still waits on the output
// register.
module keyed_record_table_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // rec_key, rec_name, rec_title, rec_value, position
  input  logic [kr_pkg::IN_DATA_W-1:0]     s_tdata,
  // action
  input  logic [kr_pkg::ACT_W-1:0]         s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // out_key, out_name, out_title, out_value, fill_count
  output logic [kr_pkg::OUT_DATA_W-1:0]    m_tdata,
  // status
  output logic [kr_pkg::STAT_W-1:0]        m_tuser
);
  import kr_pkg::*;

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_FINISH} state_t;

  state_t           state;
  action_t          op;
  rec_t             req_rec;
  logic [POS_W-1:0] req_pos;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] step;
  logic [CNT_W-1:0] step_inc;
  logic [IDX_W-1:0] mark;
  logic             found;
  rec_t             hit_rec;
  rec_t             out_rec;
  logic [CNT_W-1:0] out_fill;
  status_t          out_status;

  rec_t             in_rec;
  rec_t             cell_q [ENTRIES];
  cell_ctrl_t       cell_ctrl;
  logic             head_hit;
  logic             match;
  logic             last_step;
  logic             out_free;
  logic             out_load;
  logic             full;

  assign in_rec.key   = s_tdata[NAME_LO-1:0];
  assign in_rec.name  = s_tdata[TITLE_LO-1:NAME_LO];
  assign in_rec.title = s_tdata[VALUE_LO-1:TITLE_LO];
  assign in_rec.value = s_tdata[POS_LO-1:VALUE_LO];

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign out_load = (state == S_FINISH) && out_free;
  assign full     = (count == CNT_W'(ENTRIES));
  assign step_inc = step + CNT_W'(1);
  assign last_step = (step_inc == count);

  assign head_hit = (op == ACT_READ) ? (CMP_W'(step) == CMP_W'(req_pos))
                                     : (cell_q[0].key == req_rec.key);
  assign match = !found && head_hit;

  always_comb begin
    cell_ctrl.count = count;
    cell_ctrl.mark  = mark;
    unique case (state)
      S_IDLE:   cell_ctrl.mode = CELL_HOLD;
      S_SCAN:   cell_ctrl.mode = CELL_ROTATE;
      S_SHIFT:  cell_ctrl.mode = CELL_CLOSE;
      S_FINISH: cell_ctrl.mode = (out_free && op == ACT_INSERT && !full) ? CELL_LOAD
                                                                         : CELL_HOLD;
    endcase
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kr_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .idx      (IDX_W'(i)),
      .next_rec (cell_q[(i + 1) % ENTRIES]),
      .head_rec (cell_q[0]),
      .load_rec (req_rec),
      .rec      (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      count    <= '0;
      found    <= 1'b0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op      <= action_t'(s_tuser);
            req_rec <= in_rec;
            req_pos <= s_tdata[POS_LO+POS_W-1:POS_LO];
            step    <= '0;
            found   <= 1'b0;
            if (action_t'(s_tuser) == ACT_INSERT || count == '0) state <= S_FINISH;
            else state <= S_SCAN;
          end
        end
        S_SCAN: begin
          step <= step_inc;
          if (match) begin
            found   <= 1'b1;
            mark    <= step[IDX_W-1:0];
            hit_rec <= cell_q[0];
          end
          if (last_step) begin
            state <= (op == ACT_DELETE && (found || match)) ? S_SHIFT : S_FINISH;
          end
        end
        S_SHIFT: begin
          count <= count - CNT_W'(1);
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_rec  <= (found && (op == ACT_SEARCH || op == ACT_READ)) ? hit_rec : '0;
            out_fill <= (op == ACT_INSERT && !full) ? count + CNT_W'(1) : count;
            unique case (op)
              ACT_INSERT: begin
                if (full) begin
                  out_status <= ST_FULL;
                end else begin
                  out_status <= ST_OK;
                  count      <= count + CNT_W'(1);
                end
              end
              ACT_DELETE: out_status <= found ? ST_OK : ST_MISSING;
              ACT_SEARCH: out_status <= found ? ST_OK : ST_MISSING;
              ACT_READ:   out_status <= found ? ST_OK : ST_RANGE;
            endcase
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign m_tdata = OUT_DATA_W'({out_fill, out_rec.value, out_rec.title,
                                out_rec.name, out_rec.key});
  assign m_tuser = out_status;

endmodule

// ===== sv/kr_cell.sv =====
// One slot of the record chain: holds a record, loads, rotates or closes a gap.
// Depends on kr_pkg.
module kr_cell (
  input  logic                       clk,
  input  kr_pkg::cell_ctrl_t         ctrl,
  input  logic [kr_pkg::IDX_W-1:0]   idx,
  input  kr_pkg::rec_t               next_rec,
  input  kr_pkg::rec_t               head_rec,
  input  kr_pkg::rec_t               load_rec,
  output kr_pkg::rec_t               rec
);
  import kr_pkg::*;

  logic [CNT_W-1:0] slot;
  rec_t             rec_next;

  assign slot = CNT_W'(idx);

  always_comb begin
    rec_next = rec;
    unique case (ctrl.mode)
      CELL_HOLD:   rec_next = rec;
      // last occupied slot takes the head back, the rest shift toward the head
      CELL_ROTATE: rec_next = (slot + CNT_W'(1) == ctrl.count) ? head_rec : next_rec;
      CELL_LOAD:   if (slot == ctrl.count) rec_next = load_rec;
      CELL_CLOSE:  if (idx >= ctrl.mark) rec_next = next_rec;
    endcase
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for keyed_record_table_core: directed and random table traffic.
// Depends on kr_pkg and the core. Results are checked against a table model kept in the bench.
module tb_top;
  import kr_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct {
    status_t          status;
    rec_t             rec;
    logic [CNT_W-1:0] count;
  } answer_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [ACT_W-1:0]      s_tuser  = ACT_INSERT;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STAT_W-1:0]     m_tuser;

  // table contents as the bench expects them, updated at each accepted word
  rec_t    held_recs[ENTRIES];
  int      held = 0;
  answer_t table_answers[$];
  int      errors = 0;
  int      quiet_cycles = 0;
  bit      calm = 1'b0;

  always #4 clk = ~clk;

  keyed_record_table_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  function automatic answer_t table_apply(action_t act, rec_t rec, logic [POS_W-1:0] pos);
    answer_t a;
    int hit;
    a.status = ST_OK;
    a.rec = '0;
    hit = -1;
    for (int p = held - 1; p >= 0; p--) begin
      if (held_recs[p].key == rec.key) hit = p;
    end
    case (act)
      ACT_INSERT: begin
        if (held >= ENTRIES) begin
          a.status = ST_FULL;
        end else begin
          held_recs[held] = rec;
          held++;
        end
      end
      ACT_DELETE: begin
        if (hit < 0) begin
          a.status = ST_MISSING;
        end else begin
          for (int q = hit; q < held - 1; q++) held_recs[q] = held_recs[q + 1];
          held--;
        end
      end
      ACT_SEARCH: begin
        if (hit < 0) a.status = ST_MISSING;
        else a.rec = held_recs[hit];
      end
      default: begin
        if (pos >= held) a.status = ST_RANGE;
        else a.rec = held_recs[pos];
      end
    endcase
    a.count = CNT_W'(held);
    return a;
  endfunction

  function automatic rec_t make_rec(logic [KEY_W-1:0] key, logic [TEXT_W-1:0] name,
                                    logic [TEXT_W-1:0] title, logic [VALUE_W-1:0] value);
    rec_t r;
    r.key = key;
    r.name = name;
    r.title = title;
    r.value = value;
    return r;
  endfunction

  function automatic logic [TEXT_W-1:0] rand_text();
    int r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  function automatic rec_t random_rec(logic [KEY_W-1:0] key);
    logic [VALUE_W-1:0] v;
    int r;
    r = $urandom_range(19);
    v = (r == 0) ? '0 : (r == 1) ? '1 : VALUE_W'($urandom());
    return make_rec(key, rand_text(), rand_text(), v);
  endfunction

  // half the keys come from those already held, so search and delete hit; small pool gives duplicates
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (held > 0 && r < 50) return held_recs[$urandom_range(held - 1)].key;
    if (r < 80) return KEY_W'($urandom_range(7));
    if (r < 85) return '1;
    if (r < 90) return '0;
    return $urandom();
  endfunction

  // valid stays high between back-to-back words; outside calm stretches it can drop before a word at random
  task automatic send_word(action_t act, rec_t rec, logic [POS_W-1:0] pos);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 9) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= IN_DATA_W'({pos, rec});
    do @(posedge clk); while (!s_tready);
    table_answers.push_back(table_apply(act, rec, pos));
  endtask

  function automatic void check_field(string what, logic [TEXT_W-1:0] got,
                                      logic [TEXT_W-1:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
      errors++;
    end
  endfunction

  always @(negedge clk) m_tready <= calm || ($urandom_range(99) >= 9);

  always @(posedge clk) begin
    answer_t want;
    rec_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[REC_W-1:0];
      if (table_answers.size() == 0) begin
        $display("%0t: unexpected result word: expected none, got %h / %h",
                 $time, m_tuser, m_tdata);
        errors++;
      end else begin
        want = table_answers.pop_front();
        check_field("status", TEXT_W'(m_tuser), TEXT_W'(want.status));
        check_field("out_key", TEXT_W'(got.key), TEXT_W'(want.rec.key));
        check_field("out_name", got.name, want.rec.name);
        check_field("out_title", got.title, want.rec.title);
        check_field("out_value", TEXT_W'(got.value), TEXT_W'(want.rec.value));
        check_field("fill_count", TEXT_W'(m_tdata[REC_W +: CNT_W]), TEXT_W'(want.count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic test_empty_table();
    send_word(ACT_READ, random_rec('0), '0);
    send_word(ACT_READ, random_rec('0), '1);
    send_word(ACT_SEARCH, random_rec('0), '0);
    send_word(ACT_DELETE, random_rec('1), '0);
  endtask

  // keys 0 and all-ones at the head, key 5 twice; last insert hits a full table
  task automatic test_fill_to_full();
    logic [KEY_W-1:0] key;
    for (int i = 0; i <= ENTRIES; i++) begin
      key = (i == 1) ? '1 : (i == 9) ? KEY_W'(5) : KEY_W'(i);
      if (i == 0) send_word(ACT_INSERT, make_rec(key, '1, '0, '1), '0);
      else if (i == 1) send_word(ACT_INSERT, make_rec(key, '0, '1, '0), '0);
      else send_word(ACT_INSERT, random_rec(key), POS_W'($urandom_range(15)));
    end
  endtask

  task automatic test_duplicate_keys();
    send_word(ACT_SEARCH, random_rec(KEY_W'(5)), '0);
    send_word(ACT_DELETE, random_rec(KEY_W'(5)), '0);
    send_word(ACT_SEARCH, random_rec(KEY_W'(5)), '0);
    send_word(ACT_READ, random_rec('0), '1);
    send_word(ACT_READ, random_rec('0), POS_W'(ENTRIES - 2));
  endtask

  // segments bias toward filling, draining or a neutral mix so the count sweeps empty to full
  task automatic test_random_mix(int n_items);
    int pct_ins, pct_del, r;
    action_t act;
    pct_ins = 35;
    pct_del = 25;
    for (int i = 0; i < n_items; i++) begin
      if (i % 60 == 0) begin
        case ($urandom_range(2))
          0: begin pct_ins = 70; pct_del = 15; end
          1: begin pct_ins = 15; pct_del = 60; end
          default: begin pct_ins = 35; pct_del = 25; end
        endcase
      end
      calm = (i >= 500 && i < 700);
      r = $urandom_range(99);
      if (r < pct_ins) act = ACT_INSERT;
      else if (r < pct_ins + pct_del) act = ACT_DELETE;
      else if (r < pct_ins + pct_del + (100 - pct_ins - pct_del) / 2) act = ACT_SEARCH;
      else act = ACT_READ;
      send_word(act, random_rec(pick_key()), POS_W'($urandom_range(15)));
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_fill_to_full();
    test_duplicate_keys();
    test_random_mix(1300);
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (table_answers.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
